@@ src/itfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package itfu_pkg;

	localparam int MAG_W       = 64;
	localparam int DIGIT_SLOTS = 22;
	localparam int DIG_VEC_W   = 4 * DIGIT_SLOTS;
	localparam int BCD_DIGITS  = 20;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int MAX_WIDTH   = 64;
	localparam int MAX_PREC    = 32;

	typedef logic [6:0] count_t;
	typedef logic [4:0] ndig_t;
	typedef logic [5:0] prec_t;

	// base selector codes
	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	// ASCII codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A     = 8'h61;

	// lowercase ASCII for one digit value
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/itfu_num_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface itfu_num_if;
	logic        valid;
	logic        ready;
	logic [63:0] magnitude;
	logic        is_negative;
	logic [1:0]  base_select;
	logic        left_justify;
	logic        force_plus;
	logic        space_sign;
	logic        alternate_form;
	logic        zero_pad;
	logic [6:0]  field_width;
	logic [5:0]  min_digits;

	modport source (
		output valid, magnitude, is_negative, base_select, left_justify, force_plus,
		       space_sign, alternate_form, zero_pad, field_width, min_digits,
		input  ready
	);

	modport sink (
		input  valid, magnitude, is_negative, base_select, left_justify, force_plus,
		       space_sign, alternate_form, zero_pad, field_width, min_digits,
		output ready
	);
endinterface

`default_nettype wire

@@ src/itfu_text_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface itfu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

`default_nettype wire

@@ src/itfu_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itfu_bcd
	import itfu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MAG_W-1:0] bin,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	// add three to every BCD digit of five or more
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// shift one binary bit into the BCD word each cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

@@ src/integer_to_text_formatter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                        Role
// num      in   magnitude, sign flag, base, flags, width, prec one number per item
// text     out  char_code, last_char                           one character per item
//
// Decimal: accept, convert in the shift-add-3 unit (one bit-step per magnitude bit and a done
// strobe), scan off leading zero digits, size the runs in SETUP and SIZE, then emit (at most 64).
// Octal and hex skip the shift-add-3 unit.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// Input ready is high only while idle; a stalled text sink holds the character register
// and the sequencer waits.

module integer_to_text_formatter_unit
	import itfu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	itfu_num_if.sink    num,
	itfu_text_if.source text
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_SIZE  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]           state_q;
	logic [DIG_VEC_W-1:0] digits_q;
	ndig_t                ndig_q;
	logic [1:0]           base_q;
	logic                 neg_q, left_q, plus_q, space_q, alt_q, zpad_q;
	count_t               width_q;
	prec_t                prec_q;
	prec_t                body_q;
	logic                 sign_en_q;
	logic [7:0]           sign_char_q;
	logic [1:0]           pre_len_q;

	count_t               padr_q, padl_q, zero_q, rem_q;
	ndig_t                dig_q;
	logic                 sign_q, pre0_q, prex_q;

	logic [7:0]           char_code_q;
	logic                 out_last_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 slot;
	logic                 emit;
	logic                 bcd_start;
	logic                 bcd_done;
	logic [BCD_W-1:0]     bcd;
	logic [DIG_VEC_W+1:0] mag_ext;
	logic [DIG_VEC_W-1:0] oct_digits;
	logic [3:0]           top_dig;

	count_t               len;
	count_t               pad;
	logic [7:0]           emit_char;

	assign accept    = num.valid && num.ready;
	assign num.ready = (state_q == ST_IDLE);
	assign slot      = !out_valid_q || text.ready;
	assign emit      = (state_q == ST_EMIT) && slot;
	assign bcd_start = accept && (num.base_select == BASE_DEC);
	assign top_dig   = digits_q[DIG_VEC_W-1 -: 4];

	itfu_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (num.magnitude),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// split the magnitude into three-bit octal digits
	always_comb begin
		mag_ext = {{(DIG_VEC_W + 2 - MAG_W){1'b0}}, num.magnitude};
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			oct_digits[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
		end
	end

	// total length of sign, prefix and body; padding up to the field width
	always_comb begin
		len = 7'(body_q) + 7'(sign_en_q) + 7'(pre_len_q);
		pad = (width_q > len) ? (width_q - len) : 7'd0;
	end

	// pick the next character in output order
	always_comb begin
		if (padr_q != 7'd0) begin
			emit_char = CH_SPACE;
		end else if (sign_q) begin
			emit_char = sign_char_q;
		end else if (pre0_q) begin
			emit_char = CH_ZERO;
		end else if (prex_q) begin
			emit_char = CH_X;
		end else if (zero_q != 7'd0) begin
			emit_char = CH_ZERO;
		end else if (dig_q != 5'd0) begin
			emit_char = digit_char(top_dig);
		end else begin
			emit_char = CH_SPACE;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (num.base_select == BASE_DEC) begin
							state_q <= ST_CONV;
						end else if (num.base_select == BASE_OCT ||
						             num.base_select == BASE_HEX) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_CONV: begin
					if (bcd_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!(top_dig == 4'd0 && ndig_q > 5'd1)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_SIZE;
				ST_SIZE:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot && rem_q == 7'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the item, build digits, size the runs, step the runs
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= num.base_select;
			neg_q   <= num.is_negative;
			left_q  <= num.left_justify;
			plus_q  <= num.force_plus;
			space_q <= num.space_sign;
			alt_q   <= num.alternate_form;
			zpad_q  <= num.zero_pad;
			width_q <= (num.field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : num.field_width;
			prec_q  <= (num.min_digits > 6'(MAX_PREC)) ? 6'(MAX_PREC) : num.min_digits;
			ndig_q  <= 5'(DIGIT_SLOTS);
			if (num.base_select == BASE_OCT) begin
				digits_q <= oct_digits;
			end else begin
				digits_q <= {{(DIG_VEC_W - MAG_W){1'b0}}, num.magnitude};
			end
		end
		if (state_q == ST_CONV && bcd_done) begin
			digits_q <= {{(DIG_VEC_W - BCD_W){1'b0}}, bcd};
		end
		// drop leading zero digits, keep at least one
		if (state_q == ST_SCAN && top_dig == 4'd0 && ndig_q > 5'd1) begin
			digits_q <= {digits_q[DIG_VEC_W-5:0], 4'd0};
			ndig_q   <= ndig_q - 5'd1;
		end
		if (state_q == ST_SETUP) begin
			body_q      <= (6'(ndig_q) > prec_q) ? 6'(ndig_q) : prec_q;
			sign_en_q   <= (base_q == BASE_DEC) && (neg_q || plus_q || space_q);
			sign_char_q <= neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
			if (alt_q && base_q == BASE_HEX) begin
				pre_len_q <= 2'd2;
			end else if (alt_q && base_q == BASE_OCT) begin
				pre_len_q <= 2'd1;
			end else begin
				pre_len_q <= 2'd0;
			end
		end
		if (state_q == ST_SIZE) begin
			padr_q <= (!left_q && !zpad_q) ? pad : 7'd0;
			padl_q <= left_q ? pad : 7'd0;
			zero_q <= 7'(body_q - 6'(ndig_q)) + ((!left_q && zpad_q) ? pad : 7'd0);
			dig_q  <= ndig_q;
			sign_q <= sign_en_q;
			pre0_q <= (pre_len_q != 2'd0);
			prex_q <= (pre_len_q == 2'd2);
			rem_q  <= len + pad;
		end
		// advance the run that supplied this character
		if (emit) begin
			rem_q <= rem_q - 7'd1;
			if (padr_q != 7'd0) begin
				padr_q <= padr_q - 7'd1;
			end else if (sign_q) begin
				sign_q <= 1'b0;
			end else if (pre0_q) begin
				pre0_q <= 1'b0;
			end else if (prex_q) begin
				prex_q <= 1'b0;
			end else if (zero_q != 7'd0) begin
				zero_q <= zero_q - 7'd1;
			end else if (dig_q != 5'd0) begin
				dig_q    <= dig_q - 5'd1;
				digits_q <= {digits_q[DIG_VEC_W-5:0], 4'd0};
			end else begin
				padl_q <= padl_q - 7'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_code_q <= emit_char;
			out_last_q  <= (rem_q == 7'd1);
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = char_code_q;
	assign text.last_char = out_last_q;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import itfu_pkg::*;

	// unsupported base code, emits no text
	localparam logic [1:0] BASE_NONE = 2'd3;

	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		logic [63:0] magnitude;
		logic        is_negative;
		logic [1:0]  base_select;
		logic        left_justify;
		logic        force_plus;
		logic        space_sign;
		logic        alternate_form;
		logic        zero_pad;
		logic [6:0]  field_width;
		logic [5:0]  min_digits;
	} number_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		int         number_id;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n;

	itfu_num_if  num_ch();
	itfu_text_if text_ch();

	integer_to_text_formatter_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	text_char_t expected_text[$];
	int         mismatch_count = 0;
	int         numbers_sent   = 0;
	bit         no_idle        = 1'b0;
	bit         hold_req       = 1'b0;
	int         hold_left      = 0;

	// clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// print one line per mismatch, count them all
	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatch_count++;
	endtask

	// build the expected characters of one number and queue them
	function automatic void predict_text(input number_t n, input int id);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] d;
		logic [7:0]  digs[DIGIT_SLOTS];
		logic [7:0]  sign_ch;
		logic [7:0]  chars[$];
		int          ndig;
		int          pre_len;
		int          width;
		int          prec;
		int          body;
		int          len;
		int          pad;
		int          zeros;
		int          i;
		text_char_t  tc;

		case (n.base_select)
			BASE_OCT: radix = 64'd8;
			BASE_DEC: radix = 64'd10;
			BASE_HEX: radix = 64'd16;
			default:  return;
		endcase

		width = (n.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(n.field_width);
		prec  = (n.min_digits > MAX_PREC) ? MAX_PREC : int'(n.min_digits);

		// digits, least significant first
		mag  = n.magnitude;
		ndig = 0;
		do begin
			d   = mag % radix;
			mag = mag / radix;
			if (ndig < DIGIT_SLOTS) begin
				digs[ndig] = (d < 64'd10) ? CH_ZERO + d[7:0] : CH_A + d[7:0] - 8'd10;
				ndig++;
			end
		end while (mag != 64'd0);

		// sign shows only in decimal
		sign_ch = 8'd0;
		if (n.base_select == BASE_DEC) begin
			if (n.is_negative)      sign_ch = CH_MINUS;
			else if (n.force_plus)  sign_ch = CH_PLUS;
			else if (n.space_sign)  sign_ch = CH_SPACE;
		end
		pre_len = 0;
		if (n.alternate_form && n.base_select == BASE_HEX) pre_len = 2;
		else if (n.alternate_form && n.base_select == BASE_OCT) pre_len = 1;

		body = (ndig > prec) ? ndig : prec;
		len  = body + ((sign_ch != 8'd0) ? 1 : 0) + pre_len;
		pad  = (len < width) ? width - len : 0;

		if (!n.left_justify && !n.zero_pad) begin
			for (i = 0; i < pad; i++) chars.push_back(CH_SPACE);
		end
		if (sign_ch != 8'd0) chars.push_back(sign_ch);
		if (pre_len > 0) chars.push_back(CH_ZERO);
		if (pre_len == 2) chars.push_back(CH_X);
		zeros = body - ndig;
		if (!n.left_justify && n.zero_pad) zeros += pad;
		for (i = 0; i < zeros; i++) chars.push_back(CH_ZERO);
		for (i = ndig; i > 0; i--) chars.push_back(digs[i - 1]);
		if (n.left_justify) begin
			for (i = 0; i < pad; i++) chars.push_back(CH_SPACE);
		end

		for (i = 0; i < chars.size(); i++) begin
			tc.ch        = chars[i];
			tc.last      = (i == chars.size() - 1);
			tc.number_id = id;
			expected_text.push_back(tc);
		end
	endfunction

	function automatic number_t make_number(input logic [63:0] mag, input logic neg,
		input logic [1:0] base, input logic left, input logic plus, input logic space,
		input logic alt, input logic zpad, input logic [6:0] width, input logic [5:0] prec);
		number_t n;
		n.magnitude      = mag;
		n.is_negative    = neg;
		n.base_select    = base;
		n.left_justify   = left;
		n.force_plus     = plus;
		n.space_sign     = space;
		n.alternate_form = alt;
		n.zero_pad       = zpad;
		n.field_width    = width;
		n.min_digits     = prec;
		return n;
	endfunction

	// random number, biased toward the interesting sizes
	function automatic number_t random_number();
		number_t n;
		case ($urandom_range(5))
			0:       n.magnitude = 64'd0;
			1:       n.magnitude = 64'($urandom_range(999));
			2:       n.magnitude = {$urandom, $urandom};
			3:       n.magnitude = {$urandom, $urandom} >> $urandom_range(63);
			4:       n.magnitude = ~64'd0 - 64'($urandom_range(3));
			default: n.magnitude = 64'd1 << $urandom_range(63);
		endcase
		n.is_negative    = 1'($urandom_range(1));
		n.base_select    = ($urandom_range(15) == 0) ? BASE_NONE : 2'($urandom_range(2));
		n.left_justify   = 1'($urandom_range(1));
		n.force_plus     = 1'($urandom_range(1));
		n.space_sign     = 1'($urandom_range(1));
		n.alternate_form = 1'($urandom_range(1));
		n.zero_pad       = 1'($urandom_range(1));
		n.field_width    = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
		                                            : 7'($urandom_range(40));
		n.min_digits     = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
		                                            : 6'($urandom_range(24));
		return n;
	endfunction

	// offer one number, hold it until accepted, then queue its text
	task automatic send_number(input number_t n);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 36) begin
			num_ch.valid <= 1'b0;
			@(negedge clk);
		end
		num_ch.valid          <= 1'b1;
		num_ch.magnitude      <= n.magnitude;
		num_ch.is_negative    <= n.is_negative;
		num_ch.base_select    <= n.base_select;
		num_ch.left_justify   <= n.left_justify;
		num_ch.force_plus     <= n.force_plus;
		num_ch.space_sign     <= n.space_sign;
		num_ch.alternate_form <= n.alternate_form;
		num_ch.zero_pad       <= n.zero_pad;
		num_ch.field_width    <= n.field_width;
		num_ch.min_digits     <= n.min_digits;
		@(posedge clk);
		while (!num_ch.ready) @(posedge clk);
		predict_text(n, numbers_sent);
		numbers_sent++;
	endtask

	// drop valid, wait for all text, then let the block settle
	task automatic wait_text_drained();
		@(negedge clk);
		num_ch.valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		// zero in every base, prefix kept
		send_number(make_number(64'd0, 0, BASE_OCT, 0, 0, 0, 1, 0, 0, 0));
		send_number(make_number(64'd0, 0, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		send_number(make_number(64'd0, 0, BASE_HEX, 0, 0, 0, 1, 0, 0, 0));
		// negative zero in decimal
		send_number(make_number(64'd0, 1, BASE_DEC, 0, 0, 0, 0, 0, 3, 0));
		// largest magnitude in every base
		send_number(make_number(~64'd0, 0, BASE_OCT, 0, 0, 0, 1, 0, 0, 0));
		send_number(make_number(~64'd0, 1, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		send_number(make_number(~64'd0, 0, BASE_HEX, 0, 0, 0, 1, 0, 0, 0));
		// sign choices in decimal
		send_number(make_number(64'd42, 0, BASE_DEC, 0, 1, 0, 0, 0, 6, 0));
		send_number(make_number(64'd42, 0, BASE_DEC, 0, 0, 1, 0, 0, 6, 0));
		send_number(make_number(64'd42, 0, BASE_DEC, 0, 1, 1, 0, 0, 6, 0));
		// sign flags ignored in octal and hex
		send_number(make_number(64'd511, 1, BASE_OCT, 0, 1, 1, 0, 0, 5, 0));
		send_number(make_number(64'hbeef, 1, BASE_HEX, 0, 1, 1, 1, 0, 9, 0));
		// zero pad after sign and prefix
		send_number(make_number(64'd77, 1, BASE_DEC, 0, 0, 0, 0, 1, 10, 0));
		send_number(make_number(64'hab, 0, BASE_HEX, 0, 0, 0, 1, 1, 12, 4));
		// zero pad ignored when left aligned
		send_number(make_number(64'd9, 0, BASE_DEC, 1, 1, 0, 0, 1, 8, 3));
		// width over range, largest width, precision over range
		send_number(make_number(64'd5, 0, BASE_DEC, 0, 0, 0, 0, 0, 7'd127, 0));
		send_number(make_number(64'd5, 0, BASE_OCT, 1, 0, 0, 1, 0, 7'd65, 0));
		send_number(make_number(64'd5, 0, BASE_HEX, 0, 0, 0, 1, 1, 7'd64, 6'd32));
		send_number(make_number(64'd123, 1, BASE_DEC, 1, 0, 0, 0, 0, 0, 6'd63));
		send_number(make_number(64'd0, 0, BASE_DEC, 0, 0, 0, 0, 0, 0, 6'd40));
		// unsupported base emits nothing
		send_number(make_number(64'd1234, 1, BASE_NONE, 1, 1, 1, 1, 1, 7'd127, 6'd63));
		send_number(make_number(64'd7, 0, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		wait_text_drained();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_number(random_number());
		wait_text_drained();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (30) send_number(random_number());
		wait_text_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_receiver_stall();
		hold_req = 1'b1;
		repeat (6) send_number(random_number());
		wait_text_drained();
	endtask

	task automatic test_pause_between_bursts();
		repeat (3) begin
			repeat (6) send_number(random_number());
			wait_text_drained();
		end
	endtask

	// receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			text_ch.ready <= 1'b0;
			hold_left--;
		end else if (no_idle) begin
			text_ch.ready <= 1'b1;
		end else begin
			text_ch.ready <= ($urandom_range(99) >= 36);
		end
	end

	// compare each accepted character with the oldest expected one
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n === 1'b1 && text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected char %02h last %b",
					text_ch.char_code, text_ch.last_char));
			end else begin
				want = expected_text.pop_front();
				if (text_ch.char_code !== want.ch) begin
					report_mismatch($sformatf("number %0d: char %02h, want %02h",
						want.number_id, text_ch.char_code, want.ch));
				end
				if (text_ch.last_char !== want.last) begin
					report_mismatch($sformatf("number %0d: last %b, want %b",
						want.number_id, text_ch.last_char, want.last));
				end
			end
		end
	end

	initial begin
		arst_n                = 1'b0;
		num_ch.valid          = 1'b0;
		num_ch.magnitude      = 64'd0;
		num_ch.is_negative    = 1'b0;
		num_ch.base_select    = BASE_OCT;
		num_ch.left_justify   = 1'b0;
		num_ch.force_plus     = 1'b0;
		num_ch.space_sign     = 1'b0;
		num_ch.alternate_form = 1'b0;
		num_ch.zero_pad       = 1'b0;
		num_ch.field_width    = 7'd0;
		num_ch.min_digits     = 6'd0;
		text_ch.ready         = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		test_directed();
		test_random(150);
		test_back_to_back();
		test_receiver_stall();
		test_random(150);
		test_pause_between_bursts();

		if (expected_text.size() != 0) begin
			report_mismatch($sformatf("%0d chars never arrived", expected_text.size()));
		end
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
